[hdl/wrv_pkg.sv]
package wrv_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    typedef logic [2:0] t_fpu_op;
    localparam t_fpu_op FPU_ADD = 3'd0;
    localparam t_fpu_op FPU_SUB = 3'd1;
    localparam t_fpu_op FPU_MUL = 3'd2;
    localparam t_fpu_op FPU_DIV = 3'd3;
    localparam t_fpu_op FPU_I2F = 3'd4;

    // Update sequence, one float operation per step
    typedef logic [3:0] t_step;
    localparam t_step STEP_KF     = 4'd0;
    localparam t_step STEP_DELTA  = 4'd1;
    localparam t_step STEP_STEP   = 4'd2;
    localparam t_step STEP_MEAN   = 4'd3;
    localparam t_step STEP_DELTA2 = 4'd4;
    localparam t_step STEP_PROD   = 4'd5;
    localparam t_step STEP_M2     = 4'd6;
    localparam t_step STEP_DEN    = 4'd7;
    localparam t_step STEP_VAR    = 4'd8;

    typedef struct packed {
        logic    load_x;
        logic    start;
        t_fpu_op op;
        t_step   step;
        logic    write;
        logic    commit;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic fpu_done;
        logic last;
    } t_sts;

endpackage

[hdl/wrv_sample_if.sv]
interface wrv_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;
    logic        last_sample;

    modport source (output valid, output sample_bits, output last_sample, input ready);
    modport sink (input valid, input sample_bits, input last_sample, output ready);
endinterface

[hdl/wrv_result_if.sv]
interface wrv_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] variance_bits;
    logic [31:0] sample_total;

    modport source (output valid, output variance_bits, output sample_total, input ready);
    modport sink (input valid, input variance_bits, input sample_total, output ready);
endinterface

[hdl/welford_running_variance_unit.sv]
// Running sample variance of single-precision samples by Welford's update. Each accepted
// sample is folded into the running mean, squared-deviation sum and count through one shared
// float unit (add, subtract, multiply, divide, integer convert, each rounded to nearest even);
// the sample flagged last also yields M2/(count-1) and the count, and the state then clears.
// The seven (or nine) float operations of a sample run back to back on the shared unit; a
// divide produces two quotient bits per cycle, and a divide with a zero, infinite or NaN
// operand skips the division steps. The next sample is taken while a finished result still
// waits on the output. NaN results come out as 0x7FC00000.
module welford_running_variance_unit #(
    parameter int COUNT_WIDTH = wrv_pkg::COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wrv_sample_if.sink   i_sample,
    wrv_result_if.source o_result
);
    import wrv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wrv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wrv_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample_bits   (i_sample.sample_bits),
        .i_last_sample   (i_sample.last_sample),
        .o_variance_bits (o_result.variance_bits),
        .o_sample_total  (o_result.sample_total)
    );

endmodule

[hdl/wrv_fpu.sv]
module wrv_fpu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  wrv_pkg::t_fpu_op i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic             o_done,
    output logic [31:0]      o_result
);
    import wrv_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIVI = 3'd1;
    localparam logic [2:0] F_DIVF = 3'd2;
    localparam logic [2:0] F_LZC  = 3'd3;
    localparam logic [2:0] F_RND  = 3'd4;
    localparam logic [2:0] F_OUT  = 3'd5;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 5'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 6'd1;
            end
        end
        return n;
    endfunction

    logic [2:0]         r_state, n_state;
    logic               r_s;
    logic signed [10:0] r_e;
    logic [47:0]        r_m;
    logic               r_spec;
    logic [31:0]        r_spec_bits;
    logic [25:0]        r_rem;
    logic [23:0]        r_div;
    logic [27:0]        r_q;
    logic [3:0]         r_iter;
    logic [9:0]         r_base;
    logic signed [10:0] r_sh;
    logic [31:0]        r_res;

    // operand unpack
    logic               sa, sb;
    logic [7:0]         ea, eb, eea, eeb;
    logic [22:0]        fa, fb;
    logic               za, zb, ia, ib, na, nb;
    logic [23:0]        ma, mb;
    logic signed [10:0] la, lb;

    always_comb begin
        sa  = i_a[31];
        sb  = i_b[31] ^ (i_op == FPU_SUB);
        ea  = i_a[30:23];
        eb  = i_b[30:23];
        fa  = i_a[22:0];
        fb  = i_b[22:0];
        za  = (ea == 8'd0) && (fa == 23'd0);
        zb  = (eb == 8'd0) && (fb == 23'd0);
        ia  = (ea == 8'hFF) && (fa == 23'd0);
        ib  = (eb == 8'hFF) && (fb == 23'd0);
        na  = (ea == 8'hFF) && (fa != 23'd0);
        nb  = (eb == 8'hFF) && (fb != 23'd0);
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        eea = (ea == 8'd0) ? 8'd1 : ea;
        eeb = (eb == 8'd0) ? 8'd1 : eb;
        la  = $signed({3'b000, eea}) - 11'sd150;
        lb  = $signed({3'b000, eeb}) - 11'sd150;
    end

    // add / subtract alignment
    logic               swap, big_s, sml_s, eff_sub, lost;
    logic [23:0]        big_m, sml_m;
    logic [7:0]         big_e, sml_e, dexp;
    logic signed [10:0] big_l;
    logic [26:0]        sml_full, sml_sh;
    logic [27:0]        big_ext, sml_al, sum;

    always_comb begin
        swap     = i_b[30:0] > i_a[30:0];
        big_m    = swap ? mb : ma;
        sml_m    = swap ? ma : mb;
        big_e    = swap ? eeb : eea;
        sml_e    = swap ? eea : eeb;
        big_l    = swap ? lb : la;
        big_s    = swap ? sb : sa;
        sml_s    = swap ? sa : sb;
        eff_sub  = big_s ^ sml_s;
        dexp     = big_e - sml_e;
        sml_full = {sml_m, 3'b000};
        if (dexp >= 8'd27) begin
            sml_sh = 27'd0;
            lost   = sml_m != 24'd0;
        end else begin
            sml_sh = sml_full >> dexp[4:0];
            lost   = |(sml_full & ((27'd1 << dexp[4:0]) - 27'd1));
        end
        big_ext = {1'b0, big_m, 3'b000};
        sml_al  = {1'b0, sml_sh[26:1], sml_sh[0] | lost};
        sum     = eff_sub ? (big_ext - sml_al) : (big_ext + sml_al);
    end

    // divide pre-normalization
    logic [4:0]         lza, lzb;
    logic [23:0]        man_a, man_b;
    logic signed [10:0] div_e;

    always_comb begin
        lza   = lzc24(ma);
        lzb   = lzc24(mb);
        man_a = ma << lza;
        man_b = mb << lzb;
        div_e = (la - $signed({6'b0, lza})) - (lb - $signed({6'b0, lzb})) - 11'sd28;
    end

    // two restoring division steps per cycle
    logic [25:0] rem1, rem2;
    logic        q1, q2;

    always_comb begin
        q1   = r_rem >= {2'b00, r_div};
        rem1 = q1 ? (r_rem - {2'b00, r_div}) : r_rem;
        rem1 = {rem1[24:0], 1'b0};
        q2   = rem1 >= {2'b00, r_div};
        rem2 = q2 ? (rem1 - {2'b00, r_div}) : rem1;
        rem2 = {rem2[24:0], 1'b0};
    end

    // normalization: leading one and target exponent
    logic [5:0]         lzm, lead;
    logic signed [10:0] ep, tgt, tb;

    always_comb begin
        lzm  = lzc48(r_m);
        lead = 6'd47 - lzm;
        ep   = r_e + $signed({5'b0, lead}) - 11'sd23;
        tgt  = (ep < -11'sd149) ? -11'sd149 : ep;
        tb   = tgt + 11'sd149;
    end

    // rounding to nearest even and packing
    logic signed [10:0] neg_sh;
    logic [5:0]         shc;
    logic [97:0]        wide;
    logic [24:0]        kept, qr;
    logic               gbit, sbit;
    logic [32:0]        packed_v;
    logic [31:0]        rounded;

    always_comb begin
        neg_sh = -r_sh;
        shc    = (r_sh > 11'sd50) ? 6'd50 : r_sh[5:0];
        wide   = {r_m, 50'b0} >> shc;
        if (r_sh <= 11'sd0) begin
            kept = {1'b0, r_m[23:0]} << neg_sh[4:0];
            gbit = 1'b0;
            sbit = 1'b0;
        end else begin
            kept = wide[74:50];
            gbit = wide[49];
            sbit = |wide[48:0];
        end
        qr       = kept + {24'd0, gbit & (sbit | kept[0])};
        packed_v = {r_base, 23'd0} + {8'd0, qr};
        if (packed_v >= {1'b0, INF_BITS}) rounded = {r_s, INF_BITS[30:0]};
        else rounded = {r_s, packed_v[30:0]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    if (i_op == FPU_DIV && !(na || nb || ia || ib || za || zb))
                        n_state = F_DIVI;
                    else n_state = F_LZC;
                end
            end
            F_DIVI:  if (r_iter == 4'd13) n_state = F_DIVF;
            F_DIVF:  n_state = F_LZC;
            F_LZC:   n_state = F_RND;
            F_RND:   n_state = F_OUT;
            F_OUT:   n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_iter <= 4'd0;
                if (i_start) begin
                    r_spec <= 1'b0;
                    case (i_op)
                        FPU_ADD, FPU_SUB: begin
                            r_m <= {20'd0, sum};
                            r_e <= big_l - 11'sd3;
                            r_s <= (sum == 28'd0) ? (sa & sb) : big_s;
                            if (na || nb || (ia && ib && (sa != sb))) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= QNAN_BITS;
                            end else if (ia || ib) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= {ia ? sa : sb, INF_BITS[30:0]};
                            end
                        end
                        FPU_MUL: begin
                            r_m <= ma * mb;
                            r_e <= la + lb;
                            r_s <= sa ^ i_b[31];
                            if (na || nb || (ia && zb) || (za && ib)) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= QNAN_BITS;
                            end else if (ia || ib) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= {sa ^ i_b[31], INF_BITS[30:0]};
                            end
                        end
                        FPU_DIV: begin
                            r_rem <= {2'b00, man_a};
                            r_div <= man_b;
                            r_e   <= div_e;
                            r_s   <= sa ^ i_b[31];
                            r_m   <= 48'd0;
                            if (na || nb || (ia && ib) || (za && zb)) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= QNAN_BITS;
                            end else if (ia || zb) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= {sa ^ i_b[31], INF_BITS[30:0]};
                            end else if (za || ib) begin
                                r_spec      <= 1'b1;
                                r_spec_bits <= {sa ^ i_b[31], 31'd0};
                            end
                        end
                        default: begin
                            r_m <= {16'd0, i_a};
                            r_e <= 11'sd0;
                            r_s <= 1'b0;
                        end
                    endcase
                end
            end
            F_DIVI: begin
                r_rem  <= rem2;
                r_q    <= {r_q[25:0], q1, q2};
                r_iter <= r_iter + 4'd1;
            end
            F_DIVF: r_m <= {19'd0, r_q, r_rem != 26'd0};
            F_LZC: begin
                if (!r_spec && r_m == 48'd0) begin
                    r_spec      <= 1'b1;
                    r_spec_bits <= {r_s, 31'd0};
                end
                r_base <= tb[9:0];
                r_sh   <= tgt - r_e;
            end
            F_RND:   r_res <= r_spec ? r_spec_bits : rounded;
            default: ;
        endcase
    end

    assign o_done   = r_state == F_OUT;
    assign o_result = r_res;

endmodule

[hdl/wrv_datapath.sv]
module wrv_datapath #(
    parameter int COUNT_WIDTH = wrv_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wrv_pkg::t_cmd i_cmd,
    output wrv_pkg::t_sts o_sts,
    input  logic [31:0]   i_sample_bits,
    input  logic          i_last_sample,
    output logic [31:0]   o_variance_bits,
    output logic [31:0]   o_sample_total
);
    import wrv_pkg::*;

    logic [31:0]            r_x, r_mean, r_m2, r_kf, r_delta, r_t, r_newmean, r_newm2;
    logic                   r_last;
    logic [COUNT_WIDTH-1:0] r_cnt, cnt_new, cnt_m1;
    logic [31:0]            r_var, r_total;
    logic [31:0]            op_a, op_b, fpu_res;
    logic                   fpu_done;

    // saturate the count at its all-ones value
    assign cnt_new = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
    assign cnt_m1  = cnt_new - 1'b1;

    always_comb begin
        op_a = r_x;
        op_b = r_mean;
        case (i_cmd.step)
            STEP_KF:     op_a = 32'(cnt_new);
            STEP_DELTA:  begin op_a = r_x;       op_b = r_mean;    end
            STEP_STEP:   begin op_a = r_delta;   op_b = r_kf;      end
            STEP_MEAN:   begin op_a = r_mean;    op_b = r_t;       end
            STEP_DELTA2: begin op_a = r_x;       op_b = r_newmean; end
            STEP_PROD:   begin op_a = r_delta;   op_b = r_t;       end
            STEP_M2:     begin op_a = r_m2;      op_b = r_t;       end
            STEP_DEN:    op_a = 32'(cnt_m1);
            STEP_VAR:    begin op_a = r_newm2;   op_b = r_t;       end
            default: ;
        endcase
    end

    wrv_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_op     (i_cmd.op),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_bits;
            r_last <= i_last_sample;
        end
        if (i_cmd.write) begin
            case (i_cmd.step)
                STEP_KF:    r_kf      <= fpu_res;
                STEP_DELTA: r_delta   <= fpu_res;
                STEP_MEAN:  r_newmean <= fpu_res;
                STEP_M2:    r_newm2   <= fpu_res;
                default:    r_t       <= fpu_res;
            endcase
        end
        if (i_cmd.load_out) begin
            r_var   <= r_t;
            r_total <= 32'(cnt_new);
        end
    end

    // running state: clear on reset and after the last sample of a set
    // commit comes with the write of the new M2, so take it straight from the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_mean <= 32'd0;
            r_m2   <= 32'd0;
            r_cnt  <= '0;
        end else if (i_cmd.commit) begin
            r_mean <= r_newmean;
            r_m2   <= fpu_res;
            r_cnt  <= cnt_new;
        end
    end

    assign o_sts.fpu_done = fpu_done;
    assign o_sts.last     = r_last;
    assign o_variance_bits = r_var;
    assign o_sample_total  = r_total;

endmodule

[hdl/wrv_ctrl.sv]
module wrv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  wrv_pkg::t_sts i_sts,
    output wrv_pkg::t_cmd o_cmd
);
    import wrv_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state, n_state;
    t_step      r_step, n_step;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        case (r_step)
            STEP_KF, STEP_DEN:       o_cmd.op = FPU_I2F;
            STEP_DELTA, STEP_DELTA2: o_cmd.op = FPU_SUB;
            STEP_STEP, STEP_VAR:     o_cmd.op = FPU_DIV;
            STEP_PROD:               o_cmd.op = FPU_MUL;
            default:                 o_cmd.op = FPU_ADD;
        endcase
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_step       = STEP_KF;
                    n_state      = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.fpu_done) begin
                    o_cmd.write = 1'b1;
                    if (r_step == STEP_M2 && !i_sts.last) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else if (r_step == STEP_VAR) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_KF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an update is in progress");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.fpu_done |-> (r_state == S_WAIT))
        else $error("float unit finished outside the wait state");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before its transaction");
    a_commit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.last)
        else $error("state committed on the last sample of a set");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import wrv_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    wrv_sample_if smp ();
    wrv_result_if res ();

    welford_running_variance_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp.sink),
        .o_result(res.source)
    );

    // Predicted running state
    logic [31:0] mean_q;
    logic [31:0] m2_q;
    logic [31:0] seen_q;

    logic [31:0] variance_queue[$];
    logic [31:0] total_queue[$];

    int  error_count;
    int  idle_cycles;
    int  hold_cycles;
    bit  rx_steady;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact float to double widening
    function automatic real widen(logic [31:0] f);
        logic [23:0] m;
        int          ex;
        m = {1'b0, f[22:0]};
        if (f[30:23] == 8'hFF) begin
            if (m != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
            return $bitstoreal({f[31], 11'h7FF, 52'd0});
        end
        if (f[30:0] == 31'd0) return $bitstoreal({f[31], 63'd0});
        if (f[30:23] == 8'd0) begin
            ex = -126;
            while (!m[23]) begin
                m = m << 1;
                ex--;
            end
        end else begin
            ex = int'(f[30:23]) - 127;
            m  = {1'b1, f[22:0]};
        end
        return $bitstoreal({f[31], 11'(ex + 1023), m[22:0], 29'd0});
    endfunction

    // Round a double to single precision, nearest even
    function automatic logic [31:0] narrow(real r);
        logic [63:0] d, sig, q, rem, half;
        int          e, sh;
        logic        s;
        d = $realtobits(r);
        s = d[63];
        e = int'(d[62:52]);
        if (e == 2047) return (d[51:0] != 0) ? QNAN_BITS : {s, INF_BITS[30:0]};
        if (e == 0) return {s, 31'd0};
        e   = e - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = 29;
        if (e < -126) sh = 29 + (-126 - e);
        if (sh > 63) sh = 63;
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (e < -126) return {s, q[30:0]};
        if (q[24]) begin
            q = q >> 1;
            e++;
        end
        if (e > 127) return {s, INF_BITS[30:0]};
        return {s, 8'(e + 127), q[22:0]};
    endfunction

    function automatic logic [31:0] fpu(t_fpu_op op, logic [31:0] a, logic [31:0] b);
        real ra, rb;
        ra = widen(a);
        rb = widen(b);
        case (op)
            FPU_ADD: return narrow(ra + rb);
            FPU_SUB: return narrow(ra - rb);
            FPU_MUL: return narrow(ra * rb);
            FPU_DIV: return narrow(ra / rb);
            default: return narrow(real'(a));
        endcase
    endfunction

    // Fold one sample into the predicted state; push the variance on the last one
    function automatic void fold_sample(logic [31:0] x, logic last);
        logic [31:0] count, kf, delta, mean, delta2, m2, den, var_bits;
        count = seen_q;
        if (count < COUNT_MAX) count = count + 1;
        kf     = fpu(FPU_I2F, count, 32'd0);
        delta  = fpu(FPU_SUB, x, mean_q);
        mean   = fpu(FPU_ADD, mean_q, fpu(FPU_DIV, delta, kf));
        delta2 = fpu(FPU_SUB, x, mean);
        m2     = fpu(FPU_ADD, m2_q, fpu(FPU_MUL, delta, delta2));
        if (!last) begin
            mean_q = mean;
            m2_q   = m2;
            seen_q = count;
            return;
        end
        den = fpu(FPU_I2F, count - 1, 32'd0);
        if (den[30:0] == 31'd0) begin
            if (m2[30:0] == 31'd0 || (m2[30:23] == 8'hFF && m2[22:0] != 0))
                var_bits = QNAN_BITS;
            else
                var_bits = {m2[31] ^ den[31], INF_BITS[30:0]};
        end else begin
            var_bits = fpu(FPU_DIV, m2, den);
        end
        if (var_bits[30:23] == 8'hFF && var_bits[22:0] != 0) var_bits = QNAN_BITS;
        variance_queue.push_back(var_bits);
        total_queue.push_back(count);
        mean_q = 32'd0;
        m2_q   = 32'd0;
        seen_q = 32'd0;
    endfunction

    // Offer one sample and hold valid high; the caller drops it when idling
    task automatic send_sample(logic [31:0] x, logic last);
        smp.valid       <= 1'b1;
        smp.sample_bits <= x;
        smp.last_sample <= last;
        do @(posedge i_clk); while (!smp.ready);
        fold_sample(x, last);
    endtask

    task automatic pause_sender(int cycles);
        smp.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (variance_queue.size() != 0);
    endtask

    function automatic logic [31:0] rand_sample();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
    endfunction

    task automatic test_directed();
        logic [31:0] vals[$];
        send_sample(32'h3F80_0000, 1'b1);              // single sample set
        send_sample(32'h3F80_0000, 1'b0);
        send_sample(32'h4040_0000, 1'b1);              // 1, 3
        send_sample(32'h7F7F_FFFF, 1'b0);
        send_sample(32'hFF7F_FFFF, 1'b1);              // overflow to infinity
        send_sample(32'h7F80_0000, 1'b0);
        send_sample(32'h3F80_0000, 1'b1);              // infinity
        send_sample(32'hFF80_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);              // NaN with payload
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0000_0001, 1'b0);              // subnormals
        send_sample(32'h8000_0001, 1'b0);
        send_sample(32'h007F_FFFF, 1'b1);
        vals = '{32'h4120_0000, 32'h4120_0000, 32'h4120_0000, 32'h4120_0000};
        foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);  // equal samples
        send_sample(32'h7FC0_0001, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int left;
        left = n_items;
        while (left > 0) begin
            int len;
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_sample(rand_sample(), (i == len - 1) || ($urandom_range(0, 31) == 0));
                left--;
                if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_sample(rand_sample(), i[0]);
        wait_drained();
    endtask

    task automatic test_long_set();
        for (int i = 0; i < 150; i++) send_sample(rand_sample(), i == 149);
        wait_drained();
    endtask

    // Result side: stall pattern, hold-off and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (variance_queue.size() == 0) begin
                    $display("%0t: unexpected result var=%h total=%0d", $time,
                             res.variance_bits, res.sample_total);
                    error_count++;
                end else begin
                    logic [31:0] ev, et;
                    ev = variance_queue.pop_front();
                    et = total_queue.pop_front();
                    if (res.variance_bits !== ev) begin
                        $display("%0t: variance expected %h actual %h", $time, ev,
                                 res.variance_bits);
                        error_count++;
                    end
                    if (res.sample_total !== et) begin
                        $display("%0t: sample total expected %0d actual %0d", $time, et,
                                 res.sample_total);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 99) == 0) rx_steady = ~rx_steady;
            if (hold_cycles > 0) begin
                hold_cycles--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= rx_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        hold_cycles     = 0;
        rx_steady       = 1'b0;
        mean_q          = 32'd0;
        m2_q            = 32'd0;
        seen_q          = 32'd0;
        i_rst_n         = 1'b0;
        smp.valid       = 1'b0;
        smp.sample_bits = 32'd0;
        smp.last_sample = 1'b0;
        res.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_long_set();
        test_random(1650);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && variance_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/wrv_pkg.sv
hdl/wrv_sample_if.sv
hdl/wrv_result_if.sv
hdl/wrv_fpu.sv
hdl/wrv_datapath.sv
hdl/wrv_ctrl.sv
hdl/welford_running_variance_unit.sv
tb/testbench.sv
